// ===== rtl/mrtdfr_pkg.sv =====
`default_nettype none

package mrtdfr_pkg;

  localparam logic [7:0]  MARKER_BYTE     = 8'hFF;
  localparam logic [3:0]  MARKER_RUN_LAST = 4'd15;
  localparam logic [15:0] MARKER_OVERHEAD = 16'd18;
  localparam logic [3:0]  HDR_LAST        = 4'd11;
  localparam logic [31:0] MAX_LENGTH_RST  = 32'd4096;
  localparam logic [15:0] RECOV_MAX       = 16'hFFFF;

  localparam logic CFG_MIN_LENGTH = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_MARKER  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_HUNT    = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_SKIP    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] timestamp;
    logic [15:0] record_type;
    logic [15:0] record_subtype;
    logic [31:0] record_length;
    logic        oversize;
    logic [15:0] recoveries;
    logic [7:0]  payload_byte;
    logic        last_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/mrtdfr_core.sv =====
`default_nettype none

module mrtdfr_core (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     step_i,
  input  wire  [7:0]              byte_i,
  input  wire  [31:0]             min_length_i,
  input  wire  [31:0]             max_length_i,
  output logic                    res_valid_o,
  output mrtdfr_pkg::result_t     res_o
);
  import mrtdfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [15:0] mlen_r, mlen_nxt;
  logic [15:0] rc_r, rc_nxt;
  logic [87:0] hdr_r;

  logic [95:0] hdr_full;
  logic [31:0] hdr_len;
  logic [15:0] ml_full;
  logic [15:0] rc_inc;
  logic        finish;
  logic [15:0] finish_len;

  assign hdr_full = {hdr_r, byte_i};
  assign hdr_len  = hdr_full[31:0];
  assign ml_full  = {mlen_r[15:8], byte_i};
  assign rc_inc   = (rc_r == RECOV_MAX) ? rc_r : rc_r + 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    mlen_nxt    = mlen_r;
    rc_nxt      = rc_r;
    res_valid_o = 1'b0;
    res_o       = '0;
    finish      = 1'b0;
    finish_len  = mlen_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r < HDR_LAST) begin
          pos_nxt = pos_r + 4'd1;
        end else begin
          pos_nxt              = 4'd0;
          res_valid_o          = 1'b1;
          res_o.timestamp      = hdr_full[95:64];
          res_o.record_type    = hdr_full[63:48];
          res_o.record_subtype = hdr_full[47:32];
          res_o.record_length  = hdr_len;
          res_o.recoveries     = rc_r;
          if (hdr_len < min_length_i) begin
            res_o.kind = KIND_REJECT;
            phase_nxt  = PH_HUNT;
          end else begin
            res_o.kind     = KIND_ACCEPT;
            res_o.oversize = (hdr_len > max_length_i);
            rc_nxt         = 16'd0;
            rem_nxt        = hdr_len;
            phase_nxt      = (hdr_len != 32'd0) ? PH_PAYLOAD : PH_HEADER;
          end
        end
      end
      PH_HUNT: begin
        if (byte_i != MARKER_BYTE) begin
          pos_nxt = 4'd0;
        end else if (pos_r < MARKER_RUN_LAST) begin
          pos_nxt = pos_r + 4'd1;
        end else begin
          pos_nxt   = 4'd0;
          mlen_nxt  = 16'd0;
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (pos_r == 4'd0) begin
          mlen_nxt = {byte_i, 8'd0};
          pos_nxt  = 4'd1;
        end else begin
          mlen_nxt = ml_full;
          pos_nxt  = 4'd0;
          if (ml_full > MARKER_OVERHEAD) begin
            rem_nxt   = {16'd0, ml_full - MARKER_OVERHEAD};
            phase_nxt = PH_SKIP;
          end else begin
            finish     = 1'b1;
            finish_len = ml_full;
          end
        end
      end
      PH_SKIP: begin
        if (rem_r > 32'd1) begin
          rem_nxt = rem_r - 32'd1;
        end else begin
          finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = byte_i;
        if (rem_r <= 32'd1) begin
          res_o.last_byte = 1'b1;
          rem_nxt         = 32'd0;
          phase_nxt       = PH_HEADER;
          pos_nxt         = 4'd0;
        end else begin
          rem_nxt = rem_r - 32'd1;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        pos_nxt   = 4'd0;
      end
    endcase

    // Closing a marker message counts one recovery and returns to header collection.
    if (finish) begin
      rc_nxt              = rc_inc;
      res_valid_o         = 1'b1;
      res_o.kind          = KIND_MARKER;
      res_o.record_length = {16'd0, finish_len};
      res_o.recoveries    = rc_inc;
      phase_nxt           = PH_HEADER;
      pos_nxt             = 4'd0;
      rem_nxt             = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= 4'd0;
      rem_r   <= 32'd0;
      mlen_r  <= 16'd0;
      rc_r    <= 16'd0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      mlen_r  <= mlen_nxt;
      rc_r    <= rc_nxt;
    end
  end

  // Header bytes shift in oldest first; the twelfth byte is taken straight from the input.
  always_ff @(posedge clk) begin
    if (step_i && phase_r == PH_HEADER) begin
      hdr_r <= {hdr_r[79:0], byte_i};
    end
  end

  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (pos_r <= HDR_LAST))
    else $error("header position out of range");

  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LENGTH) |-> (pos_r <= 4'd1))
    else $error("length position out of range");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP || phase_r == PH_PAYLOAD) |-> (rem_r != 32'd0))
    else $error("skip or payload phase with nothing remaining");

  a_rc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && res_valid_o && res_o.kind == KIND_ACCEPT) |=> (rc_r == 16'd0))
    else $error("recovery count not cleared by accepted header");

endmodule

`default_nettype wire

// ===== rtl/mrtdfr_obuf.sv =====
`default_nettype none

module mrtdfr_obuf (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    load_i,
  input  mrtdfr_pkg::result_t    res_i,
  output logic                   ready_o,
  output logic                   out_valid,
  input  wire                    out_stall,
  output mrtdfr_pkg::result_t    res_o
);
  import mrtdfr_pkg::*;

  logic    valid_r;
  result_t res_r;

  // The register can take a new result when empty or when its transaction completes now.
  assign ready_o   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_o     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && load_i) begin
      res_r <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mrt_record_deframer_with_resync.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    in_data_byte
// out       output     out_valid/out_stall  out_kind .. out_last_byte
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One byte is taken per clock while in_stall is low; the sustained rate is one
// byte per cycle when out_stall stays low. A byte is held in the input
// register, then the state update and result decode run combinationally
// into the output register, from which its result leaves.
// rst_n is synchronous; it returns to header collection with counts cleared.
// in_stall rises only when the input register is full and the output register
// holds a result that out_stall is holding back.

module mrt_record_deframer_with_resync (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_timestamp,
  output logic [15:0] out_record_type,
  output logic [15:0] out_record_subtype,
  output logic [31:0] out_record_length,
  output logic        out_oversize,
  output logic [15:0] out_recoveries,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_data
);
  import mrtdfr_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] min_length_r;
  logic [31:0] max_length_r;
  logic        obuf_ready;
  logic        step;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign step     = s1_valid_r && obuf_ready;
  assign in_stall = s1_valid_r && !obuf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= 32'd0;
      max_length_r <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LENGTH: min_length_r <= cfg_data;
        CFG_MAX_LENGTH: max_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mrtdfr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (step),
    .byte_i       (s1_byte_r),
    .min_length_i (min_length_r),
    .max_length_i (max_length_r),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  mrtdfr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (step && res_valid),
    .res_i     (res),
    .ready_o   (obuf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_timestamp      = out_res.timestamp;
  assign out_record_type    = out_res.record_type;
  assign out_record_subtype = out_res.record_subtype;
  assign out_record_length  = out_res.record_length;
  assign out_oversize       = out_res.oversize;
  assign out_recoveries     = out_res.recoveries;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_last_byte      = out_res.last_byte;

endmodule

`default_nettype wire
